[src/ole_pkg.sv]
// ----------------------------------------------------------------------------
// ole_pkg
// Types and codes shared by the ordered list engine and its storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    localparam logic signed [31:0] READ_FAIL = -32'sd1;

    typedef struct packed {
        logic [2:0]         command;
        logic [4:0]         position;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [3:0]         found_index;
        logic [4:0]         count;
        logic               is_empty;
    } t_out_word;

    // per-cell control, decoded once per command by the top level
    typedef struct packed {
        logic live;        // cell holds a valid entry
        logic load;        // write the command value
        logic take_lower;  // shift up: take the entry of the cell below
        logic take_upper;  // shift down: take the entry of the cell above
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/ole_cell.sv]
// ----------------------------------------------------------------------------
// ole_cell
// One list entry: shifts with its neighbors, loads and compares for search.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_cell (
    input  wire logic               i_clk,
    input  wire ole_pkg::t_cell_ctl i_ctl,
    input  wire logic signed [31:0] i_lower,
    input  wire logic signed [31:0] i_upper,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_hit,
    output logic signed [31:0]      o_data,
    output logic                    o_hit,
    output logic                    o_first
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               w_match;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_value;
        end else if (i_ctl.take_lower) begin
            n_data = i_lower;
        end else if (i_ctl.take_upper) begin
            n_data = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign w_match = i_ctl.live && (r_data == i_value);
    assign o_data  = r_data;
    assign o_hit   = i_hit | w_match;
    assign o_first = w_match & ~i_hit;

endmodule

`default_nettype wire

[src/ordered_list_engine_top.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Fixed-capacity ordered list of signed words in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  word
//  command   in         i_in_valid / o_in_stall    i_in_word  (t_in_word)
//  result    out        o_out_valid / i_out_stall  o_out_word (t_out_word)
//
//  One word per cycle while the result is not stalled: every cell shifts, loads
//  or compares in the same cycle, and the result is registered in the output
//  stage in the cycle after accept. The search hit chain runs through all cells.
//  Reset clears the entry count and the output valid flag; entries are not reset.
//  A stalled result holds the input off until it is taken.
`default_nettype none

module ordered_list_engine_top #(
    parameter int CAPACITY = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ole_pkg::t_in_word i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ole_pkg::t_out_word     o_out_word
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    ole_pkg::t_out_word   r_out;
    ole_pkg::t_out_word   n_out;

    logic                 w_acc;
    logic [CW-1:0]        w_pos;
    logic                 w_full;
    logic                 w_pos_in;
    logic                 w_ins_ok;
    logic                 w_del_ok;
    ole_pkg::t_cmd        w_cmd;

    ole_pkg::t_cell_ctl   w_ctl   [CAPACITY];
    logic signed [31:0]   w_data  [CAPACITY];
    logic                 w_hit   [CAPACITY];
    logic                 w_first [CAPACITY];
    logic [CAPACITY-1:0]  w_first_vec;
    logic signed [31:0]   w_rd;
    logic [CW-1:0]        w_found;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_acc      = i_in_valid & ~o_in_stall;
    assign w_cmd      = ole_pkg::t_cmd'(i_in_word.command);
    assign w_pos      = CW'(i_in_word.position);
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_pos_in   = (w_pos < r_count);
    assign w_ins_ok   = (w_cmd == ole_pkg::CMD_INSERT) && !w_full && (w_pos <= r_count);
    assign w_del_ok   = (w_cmd == ole_pkg::CMD_DELETE) && w_pos_in;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [31:0] w_lower;
        logic signed [31:0] w_upper;
        logic               w_hit_in;

        assign w_ctl[k].live       = (CW'(k) < r_count);
        assign w_ctl[k].load       = w_acc && w_ins_ok && (CW'(k) == w_pos);
        assign w_ctl[k].take_lower = w_acc && w_ins_ok && (CW'(k) > w_pos);
        assign w_ctl[k].take_upper = w_acc && w_del_ok && (CW'(k) >= w_pos);

        if (k == 0) begin : g_first
            assign w_lower  = i_in_word.value;
            assign w_hit_in = 1'b0;
        end else begin : g_mid
            assign w_lower  = w_data[k-1];
            assign w_hit_in = w_hit[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_upper = w_data[k];
        end else begin : g_next
            assign w_upper = w_data[k+1];
        end

        ole_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[k]),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .i_value (i_in_word.value),
            .i_hit   (w_hit_in),
            .o_data  (w_data[k]),
            .o_hit   (w_hit[k]),
            .o_first (w_first[k])
        );

        assign w_first_vec[k] = w_first[k];
    end

    always_comb begin
        w_rd    = '0;
        w_found = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CW'(k) == w_pos) begin
                w_rd = w_rd | w_data[k];
            end
            if (w_first[k]) begin
                w_found = w_found | CW'(k);
            end
        end
    end

    always_comb begin
        n_count            = r_count;
        n_out.status       = ole_pkg::ST_OK;
        n_out.read_value   = '0;
        n_out.found_index  = '0;
        unique case (w_cmd)
            ole_pkg::CMD_INSERT: begin
                if (w_ins_ok) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_out.status = ole_pkg::ST_BAD;
                end
            end
            ole_pkg::CMD_DELETE: begin
                if (w_del_ok) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_out.status = ole_pkg::ST_BAD;
                end
            end
            ole_pkg::CMD_READ: begin
                if (w_pos_in) begin
                    n_out.read_value = w_rd;
                end else begin
                    n_out.status     = ole_pkg::ST_BAD;
                    n_out.read_value = ole_pkg::READ_FAIL;
                end
            end
            ole_pkg::CMD_SEARCH: begin
                if (w_hit[CAPACITY-1]) begin
                    n_out.found_index = w_found[3:0];
                end else begin
                    n_out.status = ole_pkg::ST_NOTFOUND;
                end
            end
            ole_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_out.status = ole_pkg::ST_BAD;
            end
        endcase
        n_out.count    = n_count[4:0];
        n_out.is_empty = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_first_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_first_vec))
        else $error("more than one first match");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd == ole_pkg::CMD_CLEAR) |=>
        (r_count == '0 && o_out_valid && o_out_word.is_empty))
        else $error("clear did not empty the list");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_ins_ok) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the list");

endmodule

`default_nettype wire

[test/tb_ordered_list_engine_top.sv]
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top
// Self-checking bench for the ordered list engine. A queue of command words
// feeds a clocked driver. The driver runs each accepted word through a local
// list model and queues the result word it expects. The monitor checks each
// result word it takes against the oldest expected word, field by field.
// A short directed run covers the edge cases. Random runs then fill and
// drain the list under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ordered_list_engine_top;

    localparam int CAPACITY         = 16;
    localparam int WORDS_PER_PHASE  = 200;
    localparam int MODE_SPAN        = 40;
    localparam int HOLD_CYCLES      = 60;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    ole_pkg::t_in_word  i_in_word   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    ole_pkg::t_out_word o_out_word;

    ole_pkg::t_in_word  pending_cmds[$];
    ole_pkg::t_out_word expected_results[$];

    // list model, updated on each accepted command word
    logic signed [31:0] list_mem [CAPACITY];
    int list_len = 0;

    // length tracked while generating, to aim positions at live entries
    int gen_len = 0;
    logic signed [31:0] recent_vals[$];

    int tx_idle_pct  = 26;
    int rx_stall_pct = 71;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int n_errors     = 0;

    ordered_list_engine_top #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic ole_pkg::t_out_word apply_command(ole_pkg::t_in_word w);
        ole_pkg::t_out_word r;
        int p;
        bit hit;
        r = '0;
        r.status = ole_pkg::ST_OK;
        p = w.position;
        hit = 1'b0;
        case (w.command)
            ole_pkg::CMD_INSERT: begin
                if (list_len >= CAPACITY || p > list_len) begin
                    r.status = ole_pkg::ST_BAD;
                end else begin
                    for (int i = list_len; i > p; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[p] = w.value;
                    list_len++;
                end
            end
            ole_pkg::CMD_DELETE: begin
                if (p >= list_len) begin
                    r.status = ole_pkg::ST_BAD;
                end else begin
                    for (int i = p; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            end
            ole_pkg::CMD_READ: begin
                if (p >= list_len) begin
                    r.status = ole_pkg::ST_BAD;
                    r.read_value = ole_pkg::READ_FAIL;
                end else begin
                    r.read_value = list_mem[p];
                end
            end
            ole_pkg::CMD_SEARCH: begin
                r.status = ole_pkg::ST_NOTFOUND;
                for (int i = 0; i < list_len; i++) begin
                    if (!hit && list_mem[i] == w.value) begin
                        hit = 1'b1;
                        r.status = ole_pkg::ST_OK;
                        r.found_index = 4'(i);
                    end
                end
            end
            ole_pkg::CMD_CLEAR: begin
                list_len = 0;
            end
            default: begin
                r.status = ole_pkg::ST_BAD;
            end
        endcase
        r.count = 5'(list_len);
        r.is_empty = (list_len == 0);
        return r;
    endfunction

    task automatic queue_command(input logic [2:0] cmd, input logic [4:0] pos,
                                 input logic signed [31:0] val);
        ole_pkg::t_in_word w;
        w.command = cmd;
        w.position = pos;
        w.value = val;
        pending_cmds.push_back(w);
        case (cmd)
            ole_pkg::CMD_INSERT: begin
                if (gen_len < CAPACITY && pos <= gen_len) begin
                    gen_len++;
                    recent_vals.push_back(val);
                    if (recent_vals.size() > 32)
                        void'(recent_vals.pop_front());
                end
            end
            ole_pkg::CMD_DELETE: if (pos < gen_len) gen_len--;
            ole_pkg::CMD_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -32'sd1;
            3:       return 32'sd0;
            4, 5:    return $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(input bit filling);
        int r;
        logic [2:0] cmd;
        logic [4:0] pos;
        logic signed [31:0] val;
        r = $urandom_range(99);
        if (filling)
            cmd = (r < 70) ? ole_pkg::CMD_INSERT : (r < 80) ? ole_pkg::CMD_DELETE :
                  (r < 88) ? ole_pkg::CMD_READ : (r < 96) ? ole_pkg::CMD_SEARCH :
                  (r < 97) ? ole_pkg::CMD_CLEAR : CMD_UNUSED_LO;
        else
            cmd = (r < 15) ? ole_pkg::CMD_INSERT : (r < 65) ? ole_pkg::CMD_DELETE :
                  (r < 80) ? ole_pkg::CMD_READ : (r < 94) ? ole_pkg::CMD_SEARCH :
                  (r < 97) ? ole_pkg::CMD_CLEAR : CMD_UNUSED_LO;
        if (cmd == CMD_UNUSED_LO)
            cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        pos = 5'($urandom_range(31));
        if ($urandom_range(99) < 85) begin
            if (cmd == ole_pkg::CMD_INSERT)
                pos = 5'($urandom_range(gen_len));
            else if ((cmd == ole_pkg::CMD_DELETE || cmd == ole_pkg::CMD_READ) && gen_len > 0)
                pos = 5'($urandom_range(gen_len - 1));
        end
        val = pick_value();
        if (cmd == ole_pkg::CMD_SEARCH && recent_vals.size() > 0 && $urandom_range(99) < 60)
            val = recent_vals[$urandom_range(recent_vals.size() - 1)];
        queue_command(cmd, pos, val);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || expected_results.size() != 0 || i_in_valid)
            @(negedge i_clk);
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            n_errors++;
        end
    endtask

    // driver: model update at accept, next word from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_word <= '0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_results.push_back(apply_command(i_in_word));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_word <= pending_cmds.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: result check and receiver stall
    always @(posedge i_clk) begin : monitor
        ole_pkg::t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_seen <= hold_req;
            hold_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word %p", $time, o_out_word);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    report_field("status", 32'(want.status), 32'(o_out_word.status));
                    report_field("read_value", want.read_value, o_out_word.read_value);
                    report_field("found_index", 32'(want.found_index),
                                 32'(o_out_word.found_index));
                    report_field("count", 32'(want.count), 32'(o_out_word.count));
                    report_field("is_empty", 32'(want.is_empty), 32'(o_out_word.is_empty));
                end
            end
            if (hold_seen != hold_req) begin
                hold_seen <= hold_req;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL ordered_list_engine_top");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, bad positions, extremes, unused codes
        queue_command(ole_pkg::CMD_READ,   5'd0,  32'sd0);
        queue_command(ole_pkg::CMD_DELETE, 5'd0,  32'sd0);
        queue_command(ole_pkg::CMD_SEARCH, 5'd0,  32'sd0);
        queue_command(ole_pkg::CMD_INSERT, 5'd1,  32'sd5);
        queue_command(ole_pkg::CMD_INSERT, 5'd0,  32'sh7FFF_FFFF);
        queue_command(ole_pkg::CMD_INSERT, 5'd1,  32'sh8000_0000);
        queue_command(ole_pkg::CMD_INSERT, 5'd1,  -32'sd1);
        queue_command(ole_pkg::CMD_INSERT, 5'd0,  32'sd0);
        queue_command(ole_pkg::CMD_READ,   5'd0,  32'sd0);
        queue_command(ole_pkg::CMD_READ,   5'd1,  32'sd0);
        queue_command(ole_pkg::CMD_READ,   5'd2,  32'sd0);
        queue_command(ole_pkg::CMD_READ,   5'd3,  32'sd0);
        queue_command(ole_pkg::CMD_READ,   5'd4,  32'sd0);
        queue_command(ole_pkg::CMD_READ,   5'd31, 32'sd0);
        queue_command(ole_pkg::CMD_SEARCH, 5'd31, -32'sd1);
        queue_command(ole_pkg::CMD_SEARCH, 5'd0,  32'sh8000_0000);
        queue_command(ole_pkg::CMD_SEARCH, 5'd0,  32'sd12345);
        queue_command(ole_pkg::CMD_DELETE, 5'd1,  32'sd0);
        queue_command(ole_pkg::CMD_DELETE, 5'd31, 32'sd0);
        queue_command(ole_pkg::CMD_INSERT, 5'd31, 32'sd7);
        queue_command(CMD_UNUSED_LO, 5'd0, 32'sd0);
        queue_command(CMD_UNUSED_LO + 3'd1, 5'd0, 32'sd0);
        queue_command(CMD_UNUSED_HI, 5'd0, 32'sd0);
        queue_command(ole_pkg::CMD_CLEAR,  5'd0,  32'sd0);
        queue_command(ole_pkg::CMD_READ,   5'd0,  32'sd0);
        wait_drained();

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 26; rx_stall_pct = 71; end
                1: begin tx_idle_pct = 71; rx_stall_pct = 26; end
                default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
            endcase
            for (n = 0; n < WORDS_PER_PHASE; n++)
                queue_random(((n / MODE_SPAN) % 2) == 0);
            if (phase == 2)
                hold_req++;
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        if (n_errors == 0)
            $display("PASS ordered_list_engine_top");
        else
            $display("FAIL ordered_list_engine_top");
        $finish;
    end

endmodule

`default_nettype wire
